FILE: rtl/lsrp_pkg.sv
// Shared types and constants for the layered shelf rectangle packer.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lsrp_pkg;

    localparam int RECT_DIM_W  = 13;  // rect_width / rect_height
    localparam int COORD_W     = 12;  // place_x / place_y
    localparam int LAYER_OUT_W = 8;   // place_layer
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_CFG_W   = 13;  // atlas_width / atlas_height
    localparam int LAYER_CFG_W = 9;   // layer_count
    localparam int PAD_W       = 8;   // pad_pixels

    localparam int DIM_RST    = 1024;
    localparam int LAYERS_RST = 1;
    localparam int PAD_RST    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1,
        CFG_LAYER_COUNT  = 2'd2,
        CFG_PAD_PIXELS   = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/lsrp_ifs.sv
// Channel interfaces of the packer: rectangle in, placement out, config write.
// Depends on lsrp_pkg for field widths and register index type.
`timescale 1ns / 1ps
`default_nettype none

interface lsrp_rect_if
    import lsrp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [RECT_DIM_W-1:0] rect_width;
    logic [RECT_DIM_W-1:0] rect_height;

    modport source (output valid, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

interface lsrp_place_if
    import lsrp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [COORD_W-1:0]     place_x;
    logic [COORD_W-1:0]     place_y;
    logic [LAYER_OUT_W-1:0] place_layer;
    logic                   placed;

    modport source (output valid, output place_x, output place_y, output place_layer,
                    output placed, input ready);
    modport sink   (input valid, input place_x, input place_y, input place_layer,
                    input placed, output ready);
endinterface

interface lsrp_cfg_if
    import lsrp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/layered_shelf_rect_packer.sv
// Layered shelf rectangle packer: input register, combinational placement, result register.
// An accepted rectangle is held in the input register, placed, then written to the result register.
// Throughput: one rectangle per cycle while results are taken (place.ready); three parallel fit checks.
// Reset: atlas 1024 x 1024, one layer, padding 1, cursor at (pad, pad), empty shelf, layer 0.
// Any config write restarts the packer; config port is always ready.
// Depends on lsrp_pkg and the interfaces in lsrp_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

module layered_shelf_rect_packer
    import lsrp_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_LAYERS = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    lsrp_rect_if.sink   rect,
    lsrp_place_if.source place,
    lsrp_cfg_if.sink    cfg
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int SDW = (DW > PAD_W) ? DW : PAD_W;          // cursor holds a coordinate or pad
    localparam int PWW = RECT_DIM_W + 1;                    // padded size width
    localparam int SW  = ((SDW + 1 > PWW) ? SDW + 1 : PWW) + 1;
    localparam int XDW = (DIM_CFG_W > DW) ? DIM_CFG_W : DW;
    localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LCW = $clog2(MAX_LAYERS + 1);
    localparam int XLW = ((LAYER_CFG_W > LCW) ? LAYER_CFG_W : LCW);
    localparam int LSW = ((LCW > LW + 1) ? LCW : LW + 1) + 1;

    localparam logic [DW-1:0]  DIM_RST_EFF =
        DW'((DIM_RST > MAX_DIM) ? MAX_DIM : DIM_RST);
    localparam logic [LCW-1:0] LAYERS_RST_EFF =
        LCW'((LAYERS_RST > MAX_LAYERS) ? MAX_LAYERS : LAYERS_RST);

    // configuration, stored already saturated
    logic [DW-1:0]    width_reg;
    logic [DW-1:0]    height_reg;
    logic [LCW-1:0]   layers_reg;
    logic [PAD_W-1:0] pad_reg;

    // packer state
    logic [SDW-1:0] col_reg, col_next;
    logic [SDW-1:0] row_reg, row_next;
    logic [DW-1:0] shelf_reg, shelf_next;
    logic [LW-1:0] layer_reg, layer_next;

    // input register
    logic                  in_valid_reg;
    logic [RECT_DIM_W-1:0] in_w_reg;
    logic [RECT_DIM_W-1:0] in_h_reg;

    // result register
    logic                   out_valid_reg;
    logic [COORD_W-1:0]     out_x_reg, out_x_next;
    logic [COORD_W-1:0]     out_y_reg, out_y_next;
    logic [LAYER_OUT_W-1:0] out_layer_reg, out_layer_next;
    logic                   out_placed_reg, out_placed_next;

    logic advance;
    logic cfg_fire;
    logic in_fire;

    logic [XDW-1:0] dim_wr;
    logic [DW-1:0]  dim_sat;
    logic [XLW-1:0] lay_wr;
    logic [LCW-1:0] lay_sat;
    logic [PAD_W-1:0] pad_restart;

    logic [SW-1:0] pw, ph, w_s, h_s, pad_s, new_row, x_s, y_s;
    logic          fit_cur, fit_row, fit_lay, pad_w_ok;
    logic [LSW-1:0] layer_inc;
    logic [SW-1:0]  x_out_s, y_out_s;
    logic [LW+LAYER_OUT_W-1:0] layer_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || place.ready);
    assign in_fire  = rect.valid && rect.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    assign rect.ready  = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign place.valid       = out_valid_reg;
    assign place.place_x     = out_x_reg;
    assign place.place_y     = out_y_reg;
    assign place.place_layer = out_layer_reg;
    assign place.placed      = out_placed_reg;

    // saturate config data on write
    always_comb
    begin
        dim_wr  = XDW'(cfg.data[DIM_CFG_W-1:0]);
        dim_sat = (dim_wr > XDW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(dim_wr);
        lay_wr  = XLW'(cfg.data[LAYER_CFG_W-1:0]);
        lay_sat = (lay_wr > XLW'(MAX_LAYERS)) ? LCW'(MAX_LAYERS) : LCW'(lay_wr);
        pad_restart = (cfg.index == CFG_PAD_PIXELS) ? cfg.data[PAD_W-1:0] : pad_reg;
    end

    // placement: current row, then a new row, then a fresh layer
    always_comb
    begin
        pw    = SW'(in_w_reg) + SW'({pad_reg, 1'b0});
        ph    = SW'(in_h_reg) + SW'({pad_reg, 1'b0});
        w_s   = SW'(width_reg);
        h_s   = SW'(height_reg);
        pad_s = SW'(pad_reg);

        new_row   = SW'(row_reg) + SW'(shelf_reg);
        pad_w_ok  = (pad_s + pw) <= w_s;
        layer_inc = LSW'(layer_reg) + LSW'(1);

        fit_cur = ((SW'(col_reg) + pw) <= w_s) && ((SW'(row_reg) + ph) <= h_s);
        fit_row = (new_row < h_s) && pad_w_ok && ((new_row + ph) <= h_s);
        fit_lay = (layer_inc < LSW'(layers_reg)) && pad_w_ok && ((pad_s + ph) <= h_s);

        col_next   = col_reg;
        row_next   = row_reg;
        shelf_next = shelf_reg;
        layer_next = layer_reg;
        x_s        = pad_s;
        y_s        = pad_s;
        out_placed_next = 1'b1;

        if (fit_cur)
        begin
            x_s = SW'(col_reg);
            y_s = SW'(row_reg);
            if (ph > SW'(shelf_reg))
            begin
                shelf_next = DW'(ph);
            end
        end
        else if (fit_row)
        begin
            y_s        = new_row;
            row_next   = SDW'(new_row);
            shelf_next = DW'(ph);
        end
        else if (fit_lay)
        begin
            layer_next = layer_inc[LW-1:0];
            row_next   = SDW'(pad_s);
            shelf_next = DW'(ph);
        end
        else
        begin
            out_placed_next = 1'b0;
        end

        if (out_placed_next)
        begin
            col_next = SDW'(x_s + pw);  // x + pw <= width, fits SDW
        end

        x_out_s   = x_s + pad_s;
        y_out_s   = y_s + pad_s;
        layer_ext = (LW + LAYER_OUT_W)'(layer_next);

        out_x_next     = out_placed_next ? x_out_s[COORD_W-1:0] : '0;
        out_y_next     = out_placed_next ? y_out_s[COORD_W-1:0] : '0;
        out_layer_next = out_placed_next ? layer_ext[LAYER_OUT_W-1:0] : '0;
    end

    // configuration and packer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RST_EFF;
            height_reg <= DIM_RST_EFF;
            layers_reg <= LAYERS_RST_EFF;
            pad_reg    <= PAD_W'(PAD_RST);
            col_reg    <= SDW'(PAD_RST);
            row_reg    <= SDW'(PAD_RST);
            shelf_reg  <= '0;
            layer_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                CFG_ATLAS_WIDTH:  width_reg  <= dim_sat;
                CFG_ATLAS_HEIGHT: height_reg <= dim_sat;
                CFG_LAYER_COUNT:  layers_reg <= lay_sat;
                CFG_PAD_PIXELS:   pad_reg    <= cfg.data[PAD_W-1:0];
                default:          pad_reg    <= pad_reg;
            endcase
            col_reg   <= SDW'(pad_restart);
            row_reg   <= SDW'(pad_restart);
            shelf_reg <= '0;
            layer_reg <= '0;
        end
        else if (advance)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            shelf_reg <= shelf_next;
            layer_reg <= layer_next;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rect.ready)
            begin
                in_valid_reg <= in_fire;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (place.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_w_reg <= rect.rect_width;
            in_h_reg <= rect.rect_height;
        end
        if (advance)
        begin
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_layer_reg  <= out_layer_next;
            out_placed_reg <= out_placed_next;
        end
    end

endmodule

`default_nettype wire
